/* rtl/core/dsp_pkg.sv */
// Shared constants, types and vertex table for the dodecahedron support point block.
package dsp_pkg;

  localparam int unsigned VERTEX_COUNT = 20;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned GROUP_SIZE   = 4;
  localparam int unsigned GROUP_COUNT  = VERTEX_COUNT / GROUP_SIZE;

  // vertex pattern components in Q2.16; one is a plain shift
  localparam int unsigned PAT_ONE_SHIFT = 16;
  localparam int unsigned PAT_PHI       = 106039;
  localparam int unsigned PAT_IPHI      = 40503;

  // scale factors, magnitude = round(eff * K / 2^30)
  localparam int unsigned SC_W     = 30;
  localparam logic [SC_W-1:0] SC_ONE  = 30'd619925131;
  localparam logic [SC_W-1:0] SC_PHI  = 30'd1003059933;
  localparam logic [SC_W-1:0] SC_IPHI = 30'd383134802;

  localparam int unsigned RADIUS_RESET = 65536;

  // component codes, sign carries the vertex sign
  typedef logic signed [2:0] code_t;
  typedef code_t [2:0] triple_t;  // [0] x, [1] y, [2] z

  localparam code_t CODE_ZERO = 3'sd0;
  localparam code_t CODE_ONE  = 3'sd1;
  localparam code_t CODE_PHI  = 3'sd2;
  localparam code_t CODE_IPHI = 3'sd3;

  function automatic triple_t mk(code_t x, code_t y, code_t z);
    triple_t t;
    t[0] = x;
    t[1] = y;
    t[2] = z;
    return t;
  endfunction

  function automatic triple_t vcode(logic [IDX_W-1:0] idx);
    triple_t t;
    t = '0;
    unique case (idx)
      5'd0:  t = mk(-CODE_ONE,  -CODE_ONE,  -CODE_ONE);
      5'd1:  t = mk(-CODE_ONE,  -CODE_ONE,   CODE_ONE);
      5'd2:  t = mk(-CODE_ONE,   CODE_ONE,  -CODE_ONE);
      5'd3:  t = mk(-CODE_ONE,   CODE_ONE,   CODE_ONE);
      5'd4:  t = mk( CODE_ONE,  -CODE_ONE,  -CODE_ONE);
      5'd5:  t = mk( CODE_ONE,  -CODE_ONE,   CODE_ONE);
      5'd6:  t = mk( CODE_ONE,   CODE_ONE,  -CODE_ONE);
      5'd7:  t = mk( CODE_ONE,   CODE_ONE,   CODE_ONE);
      5'd8:  t = mk( CODE_ZERO, -CODE_IPHI, -CODE_PHI);
      5'd9:  t = mk( CODE_ZERO, -CODE_IPHI,  CODE_PHI);
      5'd10: t = mk( CODE_ZERO,  CODE_IPHI, -CODE_PHI);
      5'd11: t = mk( CODE_ZERO,  CODE_IPHI,  CODE_PHI);
      5'd12: t = mk(-CODE_IPHI, -CODE_PHI,   CODE_ZERO);
      5'd13: t = mk(-CODE_IPHI,  CODE_PHI,   CODE_ZERO);
      5'd14: t = mk( CODE_IPHI, -CODE_PHI,   CODE_ZERO);
      5'd15: t = mk( CODE_IPHI,  CODE_PHI,   CODE_ZERO);
      5'd16: t = mk(-CODE_PHI,   CODE_ZERO, -CODE_IPHI);
      5'd17: t = mk(-CODE_PHI,   CODE_ZERO,  CODE_IPHI);
      5'd18: t = mk( CODE_PHI,   CODE_ZERO, -CODE_IPHI);
      5'd19: t = mk( CODE_PHI,   CODE_ZERO,  CODE_IPHI);
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* rtl/core/dodecahedron_support_point.sv */
// Dodecahedron support point: six-stage pipeline from direction to scaled vertex.
// Takes one direction and crust per cycle while the output is not stalled and returns
// the vertex of a regular dodecahedron about the origin with the largest dot product
// against the direction (lowest index on ties) and that vertex scaled by
// (circumradius - crust, clamped at zero) over sqrt3. Every stage is one register deep,
// so a new transaction can enter every cycle unless the output stalls. Stages: constant
// multiplies of the direction, 20 vertex scores, argmax over groups of four, final argmax,
// scale partial products, rounding and sign. Backpressure stalls only the stages that
// hold data, so bubbles are squeezed out. circumradius is written on the cfg channel,
// which is always ready, and must only change while the pipe is empty.
module dodecahedron_support_point #(
  parameter int unsigned COORD_WIDTH = 24,
  parameter int unsigned DIR_WIDTH   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [COORD_WIDTH-1:0] cfg_data_i,   // circumradius, Q8.16

  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // dir_x, dir_y, dir_z, crust from the lowest bit up, zero padded
  input  logic [((3*DIR_WIDTH+COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,

  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // point_x, point_y, point_z, vertex_index from the lowest bit up, zero padded
  output logic [((3*(COORD_WIDTH+1)+dsp_pkg::IDX_W+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned DW    = DIR_WIDTH;
  localparam int unsigned PW    = DW + 18;          // direction times pattern
  localparam int unsigned SW    = PW + 2;           // sum of three terms
  localparam int unsigned IDX_W = dsp_pkg::IDX_W;
  localparam int unsigned NV    = dsp_pkg::VERTEX_COUNT;
  localparam int unsigned GS    = dsp_pkg::GROUP_SIZE;
  localparam int unsigned NG    = dsp_pkg::GROUP_COUNT;
  localparam int unsigned SC_W  = dsp_pkg::SC_W;
  localparam int unsigned LO_W  = (CW + 1) / 2;
  localparam int unsigned HI_W  = CW - LO_W;
  localparam int unsigned PH_W  = HI_W + SC_W;
  localparam int unsigned PL_W  = LO_W + SC_W;
  localparam int unsigned SUM_W = CW + SC_W + 1;
  localparam int unsigned OW    = CW + 1;
  localparam int unsigned OUT_W = ((3*OW+IDX_W+7)/8)*8;
  localparam int unsigned NS    = 6;

  localparam logic signed [PW-1:0] PHI_S  = PW'(dsp_pkg::PAT_PHI);
  localparam logic signed [PW-1:0] IPHI_S = PW'(dsp_pkg::PAT_IPHI);
  localparam logic [SUM_W-1:0]     HALF   = SUM_W'(1) << (SC_W - 1);

  // configuration register
  logic [CW-1:0] radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= CW'(dsp_pkg::RADIUS_RESET);
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  // stage valids and load enables
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[NS-1];

  // stage 1: direction multiples and effective radius
  logic signed [DW-1:0] dir_in [3];
  logic [CW-1:0]        crust_in;
  logic [CW-1:0]        eff_d;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dir_in[j] = $signed(s_axis_tdata[j*DW +: DW]);
    end
    crust_in = s_axis_tdata[3*DW +: CW];
    eff_d    = (radius_q > crust_in) ? (radius_q - crust_in) : '0;
  end

  logic signed [DW-1:0] d1_q    [3];
  logic signed [PW-1:0] dphi1_q [3];
  logic signed [PW-1:0] diphi1_q[3];
  logic [CW-1:0]        eff1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        d1_q[j]     <= dir_in[j];
        dphi1_q[j]  <= PW'(dir_in[j]) * PHI_S;
        diphi1_q[j] <= PW'(dir_in[j]) * IPHI_S;
      end
      eff1_q <= eff_d;
    end
  end

  // stage 2: score of every vertex
  function automatic logic signed [SW-1:0] term(dsp_pkg::code_t code,
                                                 logic signed [PW-1:0] vone,
                                                 logic signed [PW-1:0] vphi,
                                                 logic signed [PW-1:0] viphi);
    logic signed [SW-1:0] m;
    dsp_pkg::code_t       a;
    a = (code < 0) ? -code : code;
    m = '0;
    unique case (a)
      dsp_pkg::CODE_ONE:  m = SW'(vone);
      dsp_pkg::CODE_PHI:  m = SW'(vphi);
      dsp_pkg::CODE_IPHI: m = SW'(viphi);
      default:            m = '0;
    endcase
    return (code < 0) ? -m : m;
  endfunction

  logic signed [SW-1:0] score_d[NV];
  logic signed [SW-1:0] score2_q[NV];
  logic [CW-1:0]        eff2_q;

  always_comb begin
    dsp_pkg::triple_t     t;
    logic signed [PW-1:0] one_v;
    for (int i = 0; i < NV; i++) begin
      t          = dsp_pkg::vcode(IDX_W'(i));
      score_d[i] = '0;
      for (int j = 0; j < 3; j++) begin
        one_v      = PW'(d1_q[j]) <<< dsp_pkg::PAT_ONE_SHIFT;
        score_d[i] = score_d[i] + term(t[j], one_v, dphi1_q[j], diphi1_q[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      score2_q <= score_d;
      eff2_q   <= eff1_q;
    end
  end

  // stage 3: best of each group of four, lowest index on ties
  logic signed [SW-1:0] gbest_d[NG];
  logic [IDX_W-1:0]     gidx_d [NG];
  logic signed [SW-1:0] gbest3_q[NG];
  logic [IDX_W-1:0]     gidx3_q [NG];
  logic [CW-1:0]        eff3_q;

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      gbest_d[g] = score2_q[g*GS];
      gidx_d[g]  = IDX_W'(g*GS);
      for (int m = 1; m < GS; m++) begin
        if (score2_q[g*GS+m] > gbest_d[g]) begin
          gbest_d[g] = score2_q[g*GS+m];
          gidx_d[g]  = IDX_W'(g*GS+m);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      gbest3_q <= gbest_d;
      gidx3_q  <= gidx_d;
      eff3_q   <= eff2_q;
    end
  end

  // stage 4: best over groups
  logic signed [SW-1:0] best_d;
  logic [IDX_W-1:0]     bidx_d;
  logic [IDX_W-1:0]     idx4_q;
  logic [CW-1:0]        eff4_q;

  always_comb begin
    best_d = gbest3_q[0];
    bidx_d = gidx3_q[0];
    for (int g = 1; g < NG; g++) begin
      if (gbest3_q[g] > best_d) begin
        best_d = gbest3_q[g];
        bidx_d = gidx3_q[g];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      idx4_q <= bidx_d;
      eff4_q <= eff3_q;
    end
  end

  // stage 5: scale partial products, radius split into halves
  dsp_pkg::triple_t  codes4;
  logic [SC_W-1:0]   k_sel[3];
  logic [PH_W-1:0]   ph5_q[3];
  logic [PL_W-1:0]   pl5_q[3];
  logic [2:0]        neg5_q;
  logic [2:0]        zero5_q;
  logic [IDX_W-1:0]  idx5_q;
  logic [CW-1:0]     eff5_q;

  always_comb begin
    dsp_pkg::code_t a;
    codes4 = dsp_pkg::vcode(idx4_q);
    for (int j = 0; j < 3; j++) begin
      a = (codes4[j] < 0) ? -codes4[j] : codes4[j];
      unique case (a)
        dsp_pkg::CODE_ONE:  k_sel[j] = dsp_pkg::SC_ONE;
        dsp_pkg::CODE_PHI:  k_sel[j] = dsp_pkg::SC_PHI;
        dsp_pkg::CODE_IPHI: k_sel[j] = dsp_pkg::SC_IPHI;
        default:            k_sel[j] = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int j = 0; j < 3; j++) begin
        ph5_q[j]   <= PH_W'(eff4_q[CW-1:LO_W]) * PH_W'(k_sel[j]);
        pl5_q[j]   <= PL_W'(eff4_q[LO_W-1:0]) * PL_W'(k_sel[j]);
        neg5_q[j]  <= codes4[j] < 0;
        zero5_q[j] <= codes4[j] == dsp_pkg::CODE_ZERO;
      end
      idx5_q <= idx4_q;
      eff5_q <= eff4_q;
    end
  end

  // stage 6: round half up, apply sign; output register
  logic [SUM_W-1:0] sum_d[3];
  logic [OW-1:0]    mag_d[3];
  logic [OW-1:0]    pt_q [3];
  logic [IDX_W-1:0] idx6_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum_d[j] = (SUM_W'(ph5_q[j]) << LO_W) + SUM_W'(pl5_q[j]) + HALF;
      mag_d[j] = sum_d[j][SUM_W-1:SC_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      for (int j = 0; j < 3; j++) begin
        if (zero5_q[j]) begin
          pt_q[j] <= '0;
        end else if (neg5_q[j]) begin
          pt_q[j] <= -mag_d[j];
        end else begin
          pt_q[j] <= mag_d[j];
        end
      end
      idx6_q <= idx5_q;
    end
  end

  assign m_axis_tdata = OUT_W'({idx6_q, pt_q[2], pt_q[1], pt_q[0]});

`ifndef NO_ASSERTIONS
  // the argmax never names a vertex outside the table
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3*OW +: IDX_W] < IDX_W'(NV)))
    else $error("vertex index out of range");

  // input may only stall when every stage holds a transaction behind a stalled output
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&v_q)))
    else $error("input stalled with a free stage");

  // zero effective radius yields the origin
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[4] && en[5] && (eff5_q == '0)) |=>
      (pt_q[0] == '0 && pt_q[1] == '0 && pt_q[2] == '0))
    else $error("nonzero point for zero radius");
`endif

endmodule

/* bench/dodecahedron_support_point_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the dodecahedron support point pipeline.
module dodecahedron_support_point_tb;

  localparam int COORD_W     = 24;
  localparam int DIR_W       = 16;
  localparam int IN_W        = ((3 * DIR_W + COORD_W + 7) / 8) * 8;
  localparam int OUT_W       = ((3 * (COORD_W + 1) + dsp_pkg::IDX_W + 7) / 8) * 8;
  localparam int VERTICES    = 20;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 340;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 10;

  // component kinds; the sign of a code is the sign of the vertex component
  localparam int C_ZERO = 0;
  localparam int C_ONE  = 1;
  localparam int C_PHI  = 2;
  localparam int C_IPHI = 3;

  // unscaled vertex pattern, Q2.16
  localparam longint PAT_ONE  = 65536;
  localparam longint PAT_PHI  = 106039;
  localparam longint PAT_IPHI = 40503;

  // radius / sqrt3 factors, magnitude = round(eff * K / 2^30)
  localparam longint unsigned K_ONE  = 64'd619925131;
  localparam longint unsigned K_PHI  = 64'd1003059933;
  localparam longint unsigned K_IPHI = 64'd383134802;

  // direction that points straight at a vertex, Q1.14
  localparam int DIR_ONE  = 16384;
  localparam int DIR_PHI  = 26510;
  localparam int DIR_IPHI = 10126;

  localparam logic [COORD_W-1:0] RADIUS_MAX = '1;

  typedef struct packed {
    logic [COORD_W-1:0]      crust;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_x;
  } direction_t;

  typedef struct packed {
    logic [dsp_pkg::IDX_W-1:0] vertex_index;
    logic signed [COORD_W:0]   point_z;
    logic signed [COORD_W:0]   point_y;
    logic signed [COORD_W:0]   point_x;
  } point_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [COORD_W-1:0] cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;   // dir_x, dir_y, dir_z, crust
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;   // point_x, point_y, point_z, vertex_index

  bit steady = 1'b0;  // no idling on either side while set
  int quiet_cycles = 0;

  dodecahedron_support_point u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // 0..7 are the cube corners, then three groups of four, first sign slowest
  function automatic void vertex_code(input int idx, output int cx, output int cy,
                                      output int cz);
    int s_first;
    int s_second;
    s_first  = (idx & 2) ? 1 : -1;
    s_second = (idx & 1) ? 1 : -1;
    if (idx < 8) begin
      cx = (idx & 4) ? C_ONE : -C_ONE;
      cy = (idx & 2) ? C_ONE : -C_ONE;
      cz = (idx & 1) ? C_ONE : -C_ONE;
    end else begin
      case ((idx - 8) / 4)
        0: begin
          cx = C_ZERO;
          cy = s_first * C_IPHI;
          cz = s_second * C_PHI;
        end
        1: begin
          cx = s_first * C_IPHI;
          cy = s_second * C_PHI;
          cz = C_ZERO;
        end
        default: begin
          cx = s_first * C_PHI;
          cy = C_ZERO;
          cz = s_second * C_IPHI;
        end
      endcase
    end
  endfunction

  function automatic longint pattern_value(int code);
    longint mag;
    case (code < 0 ? -code : code)
      C_ONE:   mag = PAT_ONE;
      C_PHI:   mag = PAT_PHI;
      C_IPHI:  mag = PAT_IPHI;
      default: mag = 0;
    endcase
    return code < 0 ? -mag : mag;
  endfunction

  function automatic logic [COORD_W:0] scaled_coord(int code, logic [COORD_W-1:0] eff);
    longint unsigned k;
    longint unsigned mag;
    logic [COORD_W:0] m;
    case (code < 0 ? -code : code)
      C_ONE:   k = K_ONE;
      C_PHI:   k = K_PHI;
      C_IPHI:  k = K_IPHI;
      default: k = 0;
    endcase
    mag = ({40'd0, eff} * k + 64'h2000_0000) >> 30;  // round half up
    m = mag[COORD_W:0];
    return code < 0 ? -m : m;
  endfunction

  function automatic int vertex_dir(int code);
    int mag;
    case (code < 0 ? -code : code)
      C_ONE:   mag = DIR_ONE;
      C_PHI:   mag = DIR_PHI;
      C_IPHI:  mag = DIR_IPHI;
      default: mag = 0;
    endcase
    return code < 0 ? -mag : mag;
  endfunction

  class support_scoreboard;
    point_t expected_points[$];
    logic [COORD_W-1:0] radius;
    int errors;

    function new();
      radius = COORD_W'(65536);
      errors = 0;
    endfunction

    function point_t support_of(direction_t d);
      longint best_score;
      longint score;
      int best;
      int cx;
      int cy;
      int cz;
      logic [COORD_W-1:0] eff;
      point_t p;
      eff = (radius > d.crust) ? radius - d.crust : '0;
      best = 0;
      best_score = 0;
      for (int i = 0; i < VERTICES; i++) begin
        vertex_code(i, cx, cy, cz);
        score = longint'($signed(d.dir_x)) * pattern_value(cx)
              + longint'($signed(d.dir_y)) * pattern_value(cy)
              + longint'($signed(d.dir_z)) * pattern_value(cz);
        // strict compare keeps the lowest index on ties
        if (i == 0 || score > best_score) begin
          best = i;
          best_score = score;
        end
      end
      vertex_code(best, cx, cy, cz);
      p.point_x = scaled_coord(cx, eff);
      p.point_y = scaled_coord(cy, eff);
      p.point_z = scaled_coord(cz, eff);
      p.vertex_index = dsp_pkg::IDX_W'(best);
      return p;
    endfunction

    function void note_direction(direction_t d);
      expected_points = {expected_points, support_of(d)};
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: (%0d, %0d, %0d) vertex %0d", got.point_x,
                   got.point_y, got.point_z, got.vertex_index);
        return;
      end
      want = expected_points.pop_front();
      if (want.point_x !== got.point_x || want.point_y !== got.point_y ||
          want.point_z !== got.point_z || want.vertex_index !== got.vertex_index) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected (%0d, %0d, %0d) vertex %0d, got (%0d, %0d, %0d) vertex %0d",
                   want.point_x, want.point_y, want.point_z, want.vertex_index,
                   got.point_x, got.point_y, got.point_z, got.vertex_index);
      end
    endfunction
  endclass

  support_scoreboard sb = new();

  // receiver: random backpressure, result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_point(m_axis_tdata);
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic direction_t make_direction(int x, int y, int z, logic [COORD_W-1:0] c);
    direction_t d;
    d.dir_x = DIR_W'(x);
    d.dir_y = DIR_W'(y);
    d.dir_z = DIR_W'(z);
    d.crust = c;
    return d;
  endfunction

  function automatic int extreme_value();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return DIR_ONE;
    endcase
  endfunction

  function automatic direction_t random_direction(logic [COORD_W-1:0] radius);
    direction_t d;
    int mode;
    int cx;
    int cy;
    int cz;
    int mag;
    int delta;
    longint c;
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      d = make_direction($urandom, $urandom, $urandom, '0);
    end else if (mode < 75) begin
      // close to a vertex, where neighbors nearly tie
      vertex_code($urandom_range(0, VERTICES - 1), cx, cy, cz);
      d = make_direction(vertex_dir(cx) + $urandom_range(0, 64) - 32,
                         vertex_dir(cy) + $urandom_range(0, 64) - 32,
                         vertex_dir(cz) + $urandom_range(0, 64) - 32, '0);
    end else if (mode < 87) begin
      d = make_direction(extreme_value(), extreme_value(), extreme_value(), '0);
    end else begin
      // equal magnitudes give exact score ties
      mag = $urandom_range(1, 32767);
      d = make_direction(mag * ($urandom_range(0, 2) - 1), mag * ($urandom_range(0, 2) - 1),
                         mag * ($urandom_range(0, 2) - 1), '0);
    end
    case ($urandom_range(0, 3))
      0: d.crust = '0;
      1: d.crust = COORD_W'($urandom);
      2: begin
        delta = int'($urandom_range(0, 8)) - 4;
        c = longint'(radius) + delta;
        if (c < 0) c = 0;
        if (c > longint'(RADIUS_MAX)) c = longint'(RADIUS_MAX);
        d.crust = COORD_W'(c);
      end
      default: d.crust = COORD_W'($urandom_range(0, radius));
    endcase
    return d;
  endfunction

  function automatic logic [COORD_W-1:0] phase_radius(int phase);
    case (phase)
      0:       return '0;
      1:       return RADIUS_MAX;
      2:       return COORD_W'($urandom);
      3:       return COORD_W'(1);
      4:       return COORD_W'(32'h0005_0000);
      default: return COORD_W'(65536);
    endcase
  endfunction

  task automatic send_item(input direction_t item);
    while (!steady && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_direction(item);
  endtask

  // hold the input off until the pipe has emptied
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_radius(input logic [COORD_W-1:0] r);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.radius = r;
  endtask

  initial begin
    int cx;
    int cy;
    int cz;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at the reset radius: aim at each vertex, then the corner cases
    for (int v = 0; v < VERTICES; v++) begin
      vertex_code(v, cx, cy, cz);
      send_item(make_direction(vertex_dir(cx), vertex_dir(cy), vertex_dir(cz),
                               COORD_W'(v * 3000)));
    end
    send_item(make_direction(0, 0, 0, '0));                    // all scores tie
    send_item(make_direction(32767, 32767, 32767, COORD_W'(65536)));  // crust equals radius
    send_item(make_direction(-32768, -32768, -32768, RADIUS_MAX));
    send_item(make_direction(32767, -32768, 0, COORD_W'(65535)));
    send_item(make_direction(DIR_ONE, DIR_ONE, 0, '0));        // scores highest at vertex 15, not a tie

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipe();
      write_radius(phase_radius(phase));
      steady = (phase == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 3 && i == PHASE_ITEMS / 2)
          drain_pipe();
        send_item(random_direction(sb.radius));
      end
    end
    steady = 1'b0;
    drain_pipe();

    if (sb.errors == 0 && sb.expected_points.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
